// ===== sv/nlb_pkg.sv =====
package nlb_pkg;

    localparam int OPCODE_W   = 3;
    localparam int INDEX_W    = 4;
    localparam int WEIGHT_W   = 16;
    localparam int TASK_W     = 8;
    localparam int DISP_W     = 24;
    localparam int AGE_W      = 16;
    localparam int TOTAL_W    = 32;
    localparam int STRAT_W    = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_DISPATCH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REGISTER   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET_HEALTH = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_A    = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B    = 3'd7;

    localparam logic [STRAT_W-1:0] STRAT_RR       = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_LEAST    = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WEIGHT   = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_RESERVED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_STRATEGY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [TASK_W-1:0]   task_kind;
        logic                health_flag;
        logic [WEIGHT_W-1:0] node_weight;
        logic [INDEX_W-1:0]  node_index;
        logic [OPCODE_W-1:0] opcode;
    } item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, start work
        logic clear;     // reset scan
        logic scan;      // one slot per cycle
        logic modulo;    // one restoring-division step
        logic commit;    // apply update, build result
    } nlb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic mod_last;
        logic needs_scan;
        logic needs_mod;
    } nlb_sts_t;

endpackage

// ===== sv/nlb_datapath.sv =====
module nlb_datapath
    import nlb_pkg::*;
#(
    parameter int NODE_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  item_t                 item,
    input  nlb_cmd_t              cmd,
    output nlb_sts_t              sts,
    output logic [119:0]          result
);

    localparam int SW = $clog2(NODE_SLOTS);
    localparam int CW = $clog2(NODE_SLOTS + 1);

    logic [STRAT_W-1:0]  strategy_reg;
    logic [AGE_W-1:0]    timeout_reg;
    item_t               item_reg;

    logic [NODE_SLOTS-1:0] present_reg, healthy_reg;
    logic [WEIGHT_W-1:0] weight_mem [NODE_SLOTS];
    logic [DISP_W-1:0]   disp_mem   [NODE_SLOTS];
    logic [AGE_W-1:0]    age_mem    [NODE_SLOTS];

    logic [TOTAL_W-1:0]  rr_reg, req_reg, fail_reg;
    logic [SW-1:0]       scan_reg;
    logic [CW-1:0]       hcnt_reg;      // healthy count during scan
    logic [CW-1:0]       seen_reg;
    logic                found_reg;
    logic [SW-1:0]       best_reg;
    logic [DISP_W-1:0]   best_disp_reg;
    logic [WEIGHT_W-1:0] best_wt_reg;
    logic                rr_found_reg;
    logic [SW-1:0]       rr_sel_reg;
    logic [CW-1:0]       rem_reg;       // remainder of rr_pointer mod healthy
    logic [5:0]          mbit_reg;
    logic [119:0]        result_reg;
    logic [119:0]        result_next;

    logic in_range;
    logic usable;
    logic [SW-1:0] idx;

    assign idx      = SW'(item_reg.node_index);
    assign in_range = ({{(32-INDEX_W){1'b0}}, item_reg.node_index} < NODE_SLOTS);
    assign usable   = present_reg[scan_reg] && healthy_reg[scan_reg];

    assign sts.scan_last  = (scan_reg == SW'(NODE_SLOTS - 1));
    assign sts.mod_last   = (mbit_reg == 6'd0);
    assign sts.needs_scan = (item_reg.opcode == OP_DISPATCH) || (item_reg.opcode == OP_TICK);
    assign sts.needs_mod  = (item_reg.opcode == OP_DISPATCH) && (strategy_reg == STRAT_RR)
                            && (hcnt_reg != '0);

    // restoring division step on remainder
    logic [CW:0] trial;
    assign trial = {rem_reg, rr_reg[mbit_reg[4:0]]} - {1'b0, hcnt_reg};

    logic [CW-1:0] hc_now, pc_now;
    always_comb
    begin
        hc_now = '0;
        pc_now = '0;
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            pc_now = pc_now + CW'(present_reg[i]);
            hc_now = hc_now + CW'(present_reg[i] & healthy_reg[i]);
        end
    end

    logic           disp_ok;
    logic [SW-1:0]  disp_sel;
    always_comb
    begin
        disp_ok  = found_reg;
        disp_sel = best_reg;
        if (strategy_reg == STRAT_RR)
        begin
            disp_ok  = rr_found_reg;
            disp_sel = rr_sel_reg;
        end
    end

    // result fields apart from the counts, taken before the commit lands
    always_comb
    begin
        result_next = '0;
        result_next[0] = 1'b1;
        result_next[72:41] = req_reg;
        result_next[104:73] = fail_reg;
        result_next[112:105] = item_reg.task_kind;
        case (item_reg.opcode)
            OP_DISPATCH:
            begin
                result_next[0] = disp_ok;
                result_next[4:1] = disp_ok ? 4'(disp_sel) : 4'd0;
                if (req_reg != '1)
                    result_next[72:41] = req_reg + 1'b1;
                if (!disp_ok && fail_reg != '1)
                    result_next[104:73] = fail_reg + 1'b1;
            end
            OP_QUERY:
                if (in_range && present_reg[idx])
                begin
                    result_next[5]    = 1'b1;
                    result_next[6]    = healthy_reg[idx];
                    result_next[30:7] = disp_mem[idx];
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= STRAT_LEAST;
            timeout_reg  <= 16'd30;
            present_reg  <= '0;
            healthy_reg  <= '0;
            rr_reg       <= '0;
            req_reg      <= '0;
            fail_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_STRATEGY: strategy_reg <= cfg_data[STRAT_W-1:0];
                    CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.scan && item_reg.opcode == OP_TICK && present_reg[scan_reg])
            begin
                if (age_mem[scan_reg] != '1 && age_mem[scan_reg] + 1'b1 > timeout_reg)
                    healthy_reg[scan_reg] <= 1'b0;
                else if (age_mem[scan_reg] == '1 && age_mem[scan_reg] > timeout_reg)
                    healthy_reg[scan_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                case (item_reg.opcode)
                    OP_DISPATCH:
                    begin
                        if (req_reg != '1)
                            req_reg <= req_reg + 1'b1;
                        if (!disp_ok && fail_reg != '1)
                            fail_reg <= fail_reg + 1'b1;
                        if (strategy_reg == STRAT_RR && hcnt_reg != '0)
                            rr_reg <= rr_reg + 1'b1;
                    end
                    OP_REGISTER:
                        if (in_range)
                        begin
                            present_reg[idx] <= 1'b1;
                            healthy_reg[idx] <= 1'b1;
                        end
                    OP_UNREGISTER:
                        if (in_range)
                        begin
                            present_reg[idx] <= 1'b0;
                            healthy_reg[idx] <= 1'b0;
                        end
                    OP_SET_HEALTH:
                        if (in_range && present_reg[idx])
                            healthy_reg[idx] <= item_reg.health_flag;
                    default: ;
                endcase
            end
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.scan && item_reg.opcode == OP_TICK && present_reg[scan_reg]
            && age_mem[scan_reg] != '1)
            age_mem[scan_reg] <= age_mem[scan_reg] + 1'b1;
        if (cmd.commit)
        begin
            case (item_reg.opcode)
                OP_DISPATCH:
                    if (disp_ok)
                    begin
                        if (disp_mem[disp_sel] != '1)
                            disp_mem[disp_sel] <= disp_mem[disp_sel] + 1'b1;
                        age_mem[disp_sel] <= '0;
                    end
                OP_REGISTER:
                    if (in_range)
                    begin
                        weight_mem[idx] <= item_reg.node_weight;
                        disp_mem[idx]   <= '0;
                        age_mem[idx]    <= '0;
                    end
                OP_SET_HEALTH:
                    if (in_range && present_reg[idx])
                        age_mem[idx] <= '0;
                default: ;
            endcase
        end
    end

    // item capture, scan, modulo and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.clear)
        begin
            scan_reg     <= '0;
            hcnt_reg     <= hc_now;
            seen_reg     <= '0;
            found_reg    <= 1'b0;
            rr_found_reg <= 1'b0;
            best_reg     <= '0;
            best_disp_reg<= '0;
            best_wt_reg  <= '0;
            rr_sel_reg   <= '0;
            rem_reg      <= '0;
            mbit_reg     <= 6'd31;
        end
        if (cmd.modulo)
        begin
            if (!trial[CW])
                rem_reg <= trial[CW-1:0];
            else
                rem_reg <= {rem_reg[CW-2:0], rr_reg[mbit_reg[4:0]]};
            mbit_reg <= mbit_reg - 1'b1;
        end
        if (cmd.scan)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (usable)
            begin
                seen_reg <= seen_reg + 1'b1;
                if (seen_reg == rem_reg && !rr_found_reg)
                begin
                    rr_found_reg <= 1'b1;
                    rr_sel_reg   <= scan_reg;
                end
                if (strategy_reg == STRAT_WEIGHT)
                begin
                    if (!found_reg || weight_mem[scan_reg] > best_wt_reg)
                    begin
                        best_reg <= scan_reg;
                        if (weight_mem[scan_reg] > best_wt_reg)
                            best_wt_reg <= weight_mem[scan_reg];
                    end
                end
                else if (!found_reg || disp_mem[scan_reg] < best_disp_reg)
                begin
                    best_reg      <= scan_reg;
                    best_disp_reg <= disp_mem[scan_reg];
                end
                found_reg <= 1'b1;
            end
        end
        if (cmd.commit)
            result_reg <= result_next;
    end

    // counts are taken after the commit lands
    always_comb
    begin
        result = result_reg;
        result[35:31] = 5'(pc_now);
        result[40:36] = 5'(hc_now);
    end

endmodule

// ===== sv/nlb_ctrl.sv =====
module nlb_ctrl
    import nlb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_fire,
    input  nlb_sts_t sts,
    output nlb_cmd_t cmd,
    output logic     busy,
    output logic     out_valid
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_MOD    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CLEAR;
                end
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
                if (!sts.needs_mod)
                    state_next = sts.needs_scan ? S_SCAN : S_COMMIT;
                else
                begin
                    cmd.modulo = 1'b1;
                    if (sts.mod_last)
                        state_next = S_SCAN;
                end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_fire)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit not followed by result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_fire) |=> out_valid) else $error("result dropped");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.clear) else $error("load without clear");

endmodule

// ===== sv/node_load_balancer_core.sv =====
// Tick and dispatch: clear, 16-slot scan, commit, result; other opcodes skip the scan.
// Round-robin dispatch with a healthy node runs a 32-step remainder before the scan.
// One item at a time; the next is accepted in the cycle after the result transfer.
// Reset (rst_n, async low): slots empty, totals and pointer zero, strategy 1, timeout 30.
module node_load_balancer_core
    import nlb_pkg::*;
#(
    parameter int NODE_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // opcode, node_index, node_weight, health_flag, task kind
    input  logic [31:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // success, selected_node, node_present, node_healthy, node_dispatches,
    // node_count, healthy_count, request total, failure total, task echo, zero pad
    output logic [119:0]          m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    nlb_cmd_t cmd;
    nlb_sts_t sts;
    logic     busy;
    item_t    item;

    assign item = s_axis_tdata;
    assign s_axis_tready = !busy;

    nlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_axis_tvalid)
    );

    nlb_datapath #(.NODE_SLOTS(NODE_SLOTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .sts      (sts),
        .result   (m_axis_tdata)
    );

endmodule

// ===== dv/node_load_balancer_core_tb.sv =====
`timescale 1ns / 1ps

class balancer_scoreboard;
    bit          present [16];
    bit          healthy [16];
    bit [15:0]   weight [16];
    bit [23:0]   disp [16];
    bit [15:0]   age [16];
    bit [31:0]   rr_ptr;
    bit [31:0]   req_total;
    bit [31:0]   fail_total;
    bit [1:0]    strategy;
    bit [15:0]   timeout;
    bit [119:0]  pending [$];
    int          mismatches;

    function new();
        strategy = 2'd1;
        timeout = 16'd30;
        rr_ptr = 0;
        req_total = 0;
        fail_total = 0;
        mismatches = 0;
        for (int i = 0; i < 16; i++)
        begin
            present[i] = 0;
            healthy[i] = 0;
            weight[i] = 0;
            disp[i] = 0;
            age[i] = 0;
        end
    endfunction

    function int choose_node();
        int hc;
        int best;
        int seen;
        int target;
        bit [15:0] top;
        hc = 0;
        best = -1;
        seen = 0;
        top = 0;
        for (int i = 0; i < 16; i++)
            if (present[i] && healthy[i])
                hc++;
        if (hc == 0)
            return -1;
        if (strategy == nlb_pkg::STRAT_RR)
        begin
            target = rr_ptr % hc;
            rr_ptr = rr_ptr + 1;
            for (int i = 0; i < 16; i++)
                if (present[i] && healthy[i])
                begin
                    if (seen == target)
                        return i;
                    seen++;
                end
            return -1;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (!(present[i] && healthy[i]))
                continue;
            if (strategy == nlb_pkg::STRAT_WEIGHT)
            begin
                if (best < 0)
                    best = i;
                if (weight[i] > top)
                begin
                    top = weight[i];
                    best = i;
                end
            end
            else if (best < 0 || disp[i] < disp[best])
                best = i;
        end
        return best;
    endfunction

    function void note_item(nlb_pkg::item_t it);
        bit        ok;
        bit [3:0]  sel;
        bit        qp;
        bit        qh;
        bit [23:0] qd;
        bit [4:0]  cnt;
        bit [4:0]  hcnt;
        int        s;
        int        ix;
        ok = 1;
        sel = 0;
        qp = 0;
        qh = 0;
        qd = 0;
        cnt = 0;
        hcnt = 0;
        ix = it.node_index;
        case (it.opcode)
            nlb_pkg::OP_DISPATCH:
            begin
                if (req_total != 32'hFFFF_FFFF)
                    req_total++;
                s = choose_node();
                if (s < 0)
                begin
                    ok = 0;
                    if (fail_total != 32'hFFFF_FFFF)
                        fail_total++;
                end
                else
                begin
                    sel = 4'(s);
                    if (disp[s] != 24'hFF_FFFF)
                        disp[s]++;
                    age[s] = 0;
                end
            end
            nlb_pkg::OP_TICK:
                for (int i = 0; i < 16; i++)
                    if (present[i])
                    begin
                        if (age[i] != 16'hFFFF)
                            age[i]++;
                        if (age[i] > timeout)
                            healthy[i] = 0;
                    end
            nlb_pkg::OP_REGISTER:
            begin
                present[ix] = 1;
                healthy[ix] = 1;
                weight[ix] = it.node_weight;
                disp[ix] = 0;
                age[ix] = 0;
            end
            nlb_pkg::OP_UNREGISTER:
            begin
                present[ix] = 0;
                healthy[ix] = 0;
            end
            nlb_pkg::OP_SET_HEALTH:
                if (present[ix])
                begin
                    healthy[ix] = it.health_flag;
                    age[ix] = 0;
                end
            nlb_pkg::OP_QUERY:
                if (present[ix])
                begin
                    qp = 1;
                    qh = healthy[ix];
                    qd = disp[ix];
                end
            default: ;
        endcase
        for (int i = 0; i < 16; i++)
            if (present[i])
            begin
                cnt++;
                if (healthy[i])
                    hcnt++;
            end
        pending.insert(pending.size(), {7'b0, it.task_kind, fail_total, req_total, hcnt,
                                        cnt, qd, qh, qp, sel, ok});
    endfunction

    function void check_result(bit [119:0] got);
        bit [119:0] exp;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result with nothing pending: %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h got %h (ok/sel %0d/%0d vs %0d/%0d)",
                         exp, got, exp[0], exp[4:1], got[0], got[4:1]);
        end
    endfunction
endclass

module node_load_balancer_core_tb;
    import nlb_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    balancer_scoreboard sb;
    int  cycle_count = 0;
    int  stall_mode = 0;
    bit  fail_hit;

    node_load_balancer_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: stall pattern changes mode now and then; every transfer is checked
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= cycle_count[2];
        endcase
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (cycle_count > 1500000)
            fail_hit <= 1'b1;
    end

    // valid stays high after the transfer; the caller drops it before a gap
    task automatic send_item(input item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic send_op(input logic [2:0] op, input int ix, input int w, input bit hf);
        item_t it;
        it.opcode = op;
        it.node_index = 4'(ix);
        it.node_weight = 16'(w);
        it.health_flag = hf;
        it.task_kind = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] a, input int v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_data <= CFG_DATA_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (a == CFG_STRATEGY)
            sb.strategy = 2'(v);
        else
            sb.timeout = 16'(v);
        @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        item_t it;
        int    left;
        int    gap;
        left = 0;
        for (int k = 0; k < n; k++)
        begin
            if (left == 0)
            begin
                left = $urandom_range(1, 30);
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            left--;
            it = $urandom;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: it.opcode = OP_DISPATCH;
                7, 8: it.opcode = OP_TICK;
                9, 10, 11: it.opcode = OP_REGISTER;
                12: it.opcode = OP_UNREGISTER;
                13, 14: it.opcode = OP_SET_HEALTH;
                15, 16, 17: it.opcode = OP_QUERY;
                default: it.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            endcase
            if ($urandom_range(0, 1))
                it.node_weight = ($urandom_range(0, 3) == 0) ? 16'd0
                                 : 16'($urandom_range(0, 1023));
            send_item(it);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, registers, each op, extremes
        send_op(OP_DISPATCH, 0, 0, 0);
        send_op(OP_QUERY, 15, 0, 0);
        send_op(OP_UNREGISTER, 3, 0, 0);
        send_op(OP_SET_HEALTH, 3, 0, 1);
        send_op(OP_REGISTER, 0, 0, 0);
        send_op(OP_REGISTER, 15, 16'hFFFF, 1);
        send_op(OP_REGISTER, 7, 256, 0);
        send_op(OP_DISPATCH, 0, 0, 0);
        send_op(OP_DISPATCH, 0, 0, 0);
        send_op(OP_QUERY, 15, 0, 0);
        send_op(OP_SET_HEALTH, 15, 0, 0);
        send_op(OP_QUERY, 15, 0, 1);
        send_op(OP_REGISTER, 15, 5, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_SPARE_A, 9, 1, 1);
        send_op(OP_SPARE_B, 2, 2, 0);
        send_op(OP_UNREGISTER, 7, 0, 0);
        send_op(OP_QUERY, 7, 0, 0);
        drain();

        write_cfg(CFG_STRATEGY, STRAT_RR);
        write_cfg(CFG_TIMEOUT, 1);
        random_phase(350);
        drain();
        write_cfg(CFG_STRATEGY, STRAT_WEIGHT);
        write_cfg(CFG_TIMEOUT, 65535);
        random_phase(350);
        drain();
        write_cfg(CFG_STRATEGY, STRAT_RESERVED);
        write_cfg(CFG_TIMEOUT, 0);
        random_phase(300);
        drain();
        write_cfg(CFG_STRATEGY, STRAT_LEAST);
        write_cfg(CFG_TIMEOUT, $urandom_range(2, 12));
        random_phase(450);
        drain();
        write_cfg(CFG_STRATEGY, STRAT_RR);
        write_cfg(CFG_TIMEOUT, $urandom_range(1, 65535));
        random_phase(450);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("node_load_balancer_core_tb: done, clean");
        else
            $display("node_load_balancer_core_tb: done, errors");
        $finish;
    end

    always @(posedge fail_hit)
    begin
        $display("node_load_balancer_core_tb: done, errors");
        $finish;
    end
endmodule
